// File: rtl/life_generation_row_stepper_unit_assert.svh
// ----------------------------------------------------------------------------
// life generation row stepper assertion macros
// shared assertion wrappers clocked on clk; LGRS_ASSERT is disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STEPPER_UNIT_ASSERT_SVH
`define LIFE_GENERATION_ROW_STEPPER_UNIT_ASSERT_SVH

// checked only out of reset
`define LGRS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define LGRS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// types, constants and the b3/s23 row rule for the life row stepper
// ----------------------------------------------------------------------------
`default_nettype none

package lgrs_pkg;

    localparam int LGRS_ROW_BITS  = 64;
    localparam int LGRS_COLS_W    = 7;
    localparam int LGRS_ROW_WIDTH = 64;
    localparam logic [LGRS_COLS_W-1:0] LGRS_COLS_RESET = 7'd64;
    localparam logic [3:0] LGRS_BIRTH   = 4'd3;
    localparam logic [3:0] LGRS_SURVIVE = 4'd2;

    typedef struct packed {
        logic [LGRS_ROW_BITS-1:0] row_cells;
        logic                     last_row;
    } row_item_t;

    typedef struct packed {
        logic [LGRS_ROW_BITS-1:0] next_row_cells;
        logic                     frame_end;
    } result_item_t;

    // one generation of the middle row, columns outside the vector are dead
    function automatic logic [LGRS_ROW_BITS-1:0] lgrs_next_gen(
        input logic [LGRS_ROW_BITS-1:0] up,
        input logic [LGRS_ROW_BITS-1:0] mid,
        input logic [LGRS_ROW_BITS-1:0] down
    );
        logic [LGRS_ROW_BITS+1:0] u;
        logic [LGRS_ROW_BITS+1:0] m;
        logic [LGRS_ROW_BITS+1:0] d;
        logic [LGRS_ROW_BITS-1:0] res;
        logic [3:0]               n;
        u = {1'b0, up, 1'b0};
        m = {1'b0, mid, 1'b0};
        d = {1'b0, down, 1'b0};
        for (int k = 0; k < LGRS_ROW_BITS; k++)
        begin
            // padded index k+1 is column k
            n = 4'(u[k]) + 4'(u[k+1]) + 4'(u[k+2])
              + 4'(m[k]) + 4'(m[k+2])
              + 4'(d[k]) + 4'(d[k+1]) + 4'(d[k+2]);
            res[k] = (n == LGRS_BIRTH) || (m[k+1] && (n == LGRS_SURVIVE));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/life_generation_row_stepper_unit.sv
// ----------------------------------------------------------------------------
// life generation row stepper unit
// streams a life grid one row per item and returns the next generation rows
// ----------------------------------------------------------------------------
// channel   | handshake                  | item
// row       | row_valid / row_stall      | row_item (row_cells, last_row)
// result    | result_valid / result_stall| result_item (next_row_cells, frame_end)
// cfg       | cfg_valid / cfg_ready      | cfg_data (active_columns)
//
// an item passes through the input register, then its results land in the
// result register; an item is taken every cycle unless row_stall is high
// a last row that follows held rows yields two results; the second waits in a
// spare register and the next item with a result behind it stalls until the spare drains
// reset clears held rows and sets the width to 64 columns
// row_stall follows result_stall in the same cycle when results back up
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_row_stepper_unit
    import lgrs_pkg::*;
#(
    parameter int ROW_WIDTH = LGRS_ROW_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   row_valid,
    output      logic                   row_stall,
    input  wire row_item_t              row_item,
    output      logic                   result_valid,
    input  wire logic                   result_stall,
    output      result_item_t           result_item,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [LGRS_COLS_W-1:0] cfg_data
);

    logic [LGRS_COLS_W-1:0] cols_reg;

    logic                 in_valid_reg;
    logic [ROW_WIDTH-1:0] in_row_reg;
    logic                 in_last_reg;

    logic [ROW_WIDTH-1:0] above_reg;
    logic [ROW_WIDTH-1:0] middle_reg;
    logic                 held_reg;

    logic                 out_valid_reg;
    result_item_t         out_item_reg;
    logic                 pend_valid_reg;
    result_item_t         pend_item_reg;

    logic [ROW_WIDTH-1:0]     mask;
    logic [ROW_WIDTH-1:0]     row_m;
    logic [ROW_WIDTH-1:0]     up_m;
    logic [LGRS_ROW_BITS-1:0] gen_mid;
    logic [LGRS_ROW_BITS-1:0] gen_last;
    result_item_t             res_mid;
    result_item_t             res_last;
    logic                     no_result;
    logic                     out_free;
    logic                     proc;

    // live column mask, clamps at ROW_WIDTH by its own width
    always_comb
    begin
        for (int k = 0; k < ROW_WIDTH; k++)
        begin
            mask[k] = (cols_reg > LGRS_COLS_W'(k));
        end
    end

    assign row_m = in_row_reg & mask;
    assign up_m  = held_reg ? (middle_reg & mask) : '0;

    assign gen_mid  = lgrs_next_gen(LGRS_ROW_BITS'(above_reg & mask),
                                    LGRS_ROW_BITS'(middle_reg & mask),
                                    LGRS_ROW_BITS'(row_m));
    assign gen_last = lgrs_next_gen(LGRS_ROW_BITS'(up_m),
                                    LGRS_ROW_BITS'(row_m),
                                    '0);

    assign res_mid.next_row_cells  = LGRS_ROW_BITS'(gen_mid[ROW_WIDTH-1:0] & mask);
    assign res_mid.frame_end       = 1'b0;
    assign res_last.next_row_cells = LGRS_ROW_BITS'(gen_last[ROW_WIDTH-1:0] & mask);
    assign res_last.frame_end      = 1'b1;

    assign no_result = !held_reg && !in_last_reg;
    assign out_free  = !pend_valid_reg && (!out_valid_reg || !result_stall);
    assign proc      = in_valid_reg && (no_result || out_free);

    assign row_stall    = in_valid_reg && !proc;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;
    assign cfg_ready    = !in_valid_reg && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= LGRS_COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cols_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!row_stall)
        begin
            in_valid_reg <= row_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_valid && !row_stall)
        begin
            in_row_reg  <= row_item.row_cells[ROW_WIDTH-1:0];
            in_last_reg <= row_item.last_row;
        end
    end

    // held rows of the current frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg  <= '0;
            middle_reg <= '0;
            held_reg   <= 1'b0;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                above_reg  <= '0;
                middle_reg <= '0;
                held_reg   <= 1'b0;
            end
            else
            begin
                above_reg  <= held_reg ? middle_reg : '0;
                middle_reg <= row_m;
                held_reg   <= 1'b1;
            end
        end
    end

    // result register plus spare for the second result of a closing row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (proc && !no_result)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= held_reg && in_last_reg;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && !no_result)
        begin
            out_item_reg  <= held_reg ? res_mid : res_last;
            pend_item_reg <= res_last;
        end
        else if (out_valid_reg && !result_stall && pend_valid_reg)
        begin
            out_item_reg <= pend_item_reg;
        end
    end

`include "life_generation_row_stepper_unit_assert.svh"

    `LGRS_ASSERT(a_pend_behind_out, pend_valid_reg |-> out_valid_reg, "spare result without result")
    `LGRS_ASSERT(a_pend_order, pend_valid_reg |-> (!out_item_reg.frame_end && pend_item_reg.frame_end), "closing results out of order")
    `LGRS_ASSERT(a_frame_clears, (proc && in_last_reg) |=> !held_reg, "rows held past frame end")
    `LGRS_ASSERT_ALWAYS(a_stall_needs_item, row_stall |-> in_valid_reg, "row stalled with empty input register")

endmodule

`default_nettype wire

// File: tb/lgrs_generation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life generation checker
// watches the row, result and width channels of the life row stepper, keeps
// its own copy of the held rows and the active width, works out the next
// generation rows each accepted item should produce and compares them in
// order against the result channel
// ----------------------------------------------------------------------------

module lgrs_generation_checker
    import lgrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   row_valid,
    input  logic                   row_stall,
    input  row_item_t              row_item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  result_item_t           result_item,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [LGRS_COLS_W-1:0] cfg_data,
    output int                     failures,
    output int                     results_owed,
    output int                     results_seen
);

    result_item_t             owed_rows[$];
    logic [LGRS_COLS_W-1:0]   active_cols;
    logic [LGRS_ROW_BITS-1:0] upper_row;
    logic [LGRS_ROW_BITS-1:0] pending_row;
    logic [1:0]               frame_depth;

    // widths past the row size act as the full row, zero kills every cell
    function automatic logic [LGRS_ROW_BITS-1:0] width_mask(
        input logic [LGRS_COLS_W-1:0] cols
    );
        if (cols >= LGRS_COLS_W'(LGRS_ROW_WIDTH))
            return {LGRS_ROW_BITS{1'b1}};
        return (64'd1 << cols) - 64'd1;
    endfunction

    // b3/s23 on one row, cells outside the vector or the mask are dead
    function automatic logic [LGRS_ROW_BITS-1:0] evolve_row(
        input logic [LGRS_ROW_BITS-1:0] above,
        input logic [LGRS_ROW_BITS-1:0] mid,
        input logic [LGRS_ROW_BITS-1:0] below,
        input logic [LGRS_ROW_BITS-1:0] mask
    );
        logic [LGRS_ROW_BITS-1:0] a;
        logic [LGRS_ROW_BITS-1:0] m;
        logic [LGRS_ROW_BITS-1:0] b;
        logic [LGRS_ROW_BITS-1:0] nxt;
        int                       neighbors;
        int                       j;
        a = above & mask;
        m = mid & mask;
        b = below & mask;
        nxt = '0;
        for (int col = 0; col < LGRS_ROW_BITS; col++)
        begin
            neighbors = 0;
            for (int dc = -1; dc <= 1; dc++)
            begin
                j = col + dc;
                if (j >= 0 && j < LGRS_ROW_BITS)
                begin
                    neighbors += a[j] + b[j];
                    if (dc != 0)
                        neighbors += m[j];
                end
            end
            nxt[col] = (neighbors == 3) || (m[col] && neighbors == 2);
        end
        return nxt & mask;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [LGRS_ROW_BITS-1:0] mask;
        logic [LGRS_ROW_BITS-1:0] cells;
        result_item_t             want;
        if (!rst_n)
        begin
            owed_rows.delete();
            active_cols  = LGRS_COLS_RESET;
            upper_row    = '0;
            pending_row  = '0;
            frame_depth  = '0;
            failures     = 0;
            results_seen = 0;
            results_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_cols = cfg_data;

            if (row_valid && !row_stall)
            begin
                mask  = width_mask(active_cols);
                cells = row_item.row_cells & mask;
                if (frame_depth != 0)
                begin
                    want.next_row_cells = evolve_row(upper_row, pending_row, cells, mask);
                    want.frame_end      = 1'b0;
                    owed_rows.push_back(want);
                end
                if (row_item.last_row)
                begin
                    want.next_row_cells = evolve_row((frame_depth != 0) ? pending_row : '0,
                                                     cells, '0, mask);
                    want.frame_end      = 1'b1;
                    owed_rows.push_back(want);
                    upper_row   = '0;
                    pending_row = '0;
                    frame_depth = '0;
                end
                else
                begin
                    upper_row   = (frame_depth != 0) ? pending_row : '0;
                    pending_row = cells;
                    frame_depth = (frame_depth != 0) ? 2'd2 : 2'd1;
                end
            end

            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (owed_rows.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected result item: cells %h frame_end %b",
                                 $time, result_item.next_row_cells, result_item.frame_end);
                end
                else
                begin
                    want = owed_rows.pop_front();
                    if (want.next_row_cells !== result_item.next_row_cells ||
                        want.frame_end !== result_item.frame_end)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: result mismatch: expected cells %h frame_end %b, got cells %h frame_end %b",
                                     $time, want.next_row_cells, want.frame_end,
                                     result_item.next_row_cells, result_item.frame_end);
                    end
                end
            end

            results_owed <= owed_rows.size();
        end
    end

endmodule

// File: tb/life_generation_row_stepper_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life generation row stepper unit test
// streams life grids through the row stepper under several column widths,
// with random gaps on the row side and random stalls on the result side, and
// lets the checker compare every next generation row
// ----------------------------------------------------------------------------

module life_generation_row_stepper_unit_test
    import lgrs_pkg::*;
();

    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ROWS   = 950;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   row_valid    = 1'b0;
    logic                   row_stall;
    row_item_t              row_item     = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_item_t           result_item;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [LGRS_COLS_W-1:0] cfg_data     = '0;

    int failures;
    int results_owed;
    int results_seen;
    int send_idle_pct    = 0;
    int result_stall_pct = 0;
    int rows_sent        = 0;
    int frames_sent      = 0;
    int widths_written   = 0;
    int cycle_count;

    life_generation_row_stepper_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_stall    (row_stall),
        .row_item     (row_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    lgrs_generation_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_stall    (row_stall),
        .row_item     (row_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .results_owed (results_owed),
        .results_seen (results_seen)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < result_stall_pct);

    task automatic push_row(input logic [LGRS_ROW_BITS-1:0] cells, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            row_valid <= 1'b0;
            @(posedge clk);
        end
        row_valid          <= 1'b1;
        row_item.row_cells <= cells;
        row_item.last_row  <= last;
        @(posedge clk);
        while (row_stall)
            @(posedge clk);
        rows_sent++;
        if (last)
            frames_sent++;
    endtask

    // hold off the row side until every owed result has come back
    task automatic drain_results();
        row_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [LGRS_COLS_W-1:0] cols);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= cols;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        widths_written++;
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("life_generation_row_stepper_unit regression: fail");
        $finish;
    end

    initial
    begin
        logic [LGRS_ROW_BITS-1:0] cells;
        logic [LGRS_ROW_BITS-1:0] a;
        logic [LGRS_ROW_BITS-1:0] b;
        int                       height;
        int                       phase_rows;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-row grid, everything alive
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b1);
        // dense frame between dead rows
        push_row('0, 1'b0);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b0);
        push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_row(64'h5555_5555_5555_5555, 1'b0);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b0);
        push_row('0, 1'b1);
        // vertical blinkers on both edge columns
        push_row(64'h8000_0000_0000_0001, 1'b0);
        push_row(64'h8000_0000_0000_0001, 1'b0);
        push_row(64'h8000_0000_0000_0001, 1'b0);
        push_row('0, 1'b1);
        // horizontal blinker
        push_row('0, 1'b0);
        push_row(64'h0000_0000_0000_0070, 1'b0);
        push_row('0, 1'b1);
        // two-row grid
        push_row(64'h3, 1'b0);
        push_row(64'h3, 1'b1);

        // one column only
        write_width(7'd1);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b0);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b0);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b1);
        // no columns at all
        write_width(7'd0);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b0);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b1);
        // widest encoding clamps to the full row
        write_width(7'd127);
        push_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b1);
        // width narrowed while rows are held
        write_width(7'd64);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b0);
        push_row(64'h0123_4567_89AB_CDEF, 1'b0);
        write_width(7'd8);
        push_row({LGRS_ROW_BITS{1'b1}}, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct    = 6;
                    result_stall_pct = 54;
                end
                1:
                begin
                    send_idle_pct    = 54;
                    result_stall_pct = 6;
                end
                default:
                begin
                    send_idle_pct    = 0;
                    result_stall_pct = 0;
                end
            endcase
            phase_rows = 0;
            while (phase_rows < RANDOM_ROWS / 3)
            begin
                if ($urandom_range(5) == 0)
                begin
                    case ($urandom_range(9))
                        0:       write_width(7'd0);
                        1:       write_width(7'($urandom_range(127, 65)));
                        2:       write_width(7'd64);
                        default: write_width(7'($urandom_range(64, 1)));
                    endcase
                end
                case ($urandom_range(9))
                    0:       height = 1;
                    1:       height = $urandom_range(40, 11);
                    default: height = $urandom_range(10, 2);
                endcase
                for (int r = 0; r < height; r++)
                begin
                    a = {$urandom, $urandom};
                    b = {$urandom, $urandom};
                    case ($urandom_range(5))
                        0:       cells = a & b & {$urandom, $urandom};
                        1:       cells = a | b;
                        2:       cells = 64'($urandom_range(7)) << $urandom_range(61);
                        3:       cells = ($urandom_range(1) == 1) ? {LGRS_ROW_BITS{1'b1}} : '0;
                        default: cells = a;
                    endcase
                    push_row(cells, r == height - 1);
                    // now and then the width moves under a half-done frame
                    if (r < height - 1 && $urandom_range(49) == 0)
                        write_width(7'($urandom_range(64, 1)));
                end
                phase_rows += height;
                if ($urandom_range(7) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d rows in %0d frames across %0d width settings", rows_sent,
                 frames_sent, widths_written);
        $display("compared %0d next generation rows, %0d failures", results_seen, failures);
        if (failures == 0)
            $display("life_generation_row_stepper_unit regression: pass");
        else
            $display("life_generation_row_stepper_unit regression: fail");
        $finish;
    end

endmodule
